FILE: design/gh_pkg.sv
// shared constants, codes and control types for the generational handle table
`timescale 1ns / 1ps
package gh_pkg;

    localparam int SLOTS_DEFAULT      = 256;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int HANDLE_W = 64;
    localparam int GEN_W    = 32;
    localparam int INDEX_W  = 32;
    localparam int VALUE_W  = 32;
    localparam int LIVE_W   = 9;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_GET    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } gh_cmd_t;

endpackage

FILE: design/gh_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module gh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/gh_ctrl.sv
// two-state sequencer: read slot, then commit and load the result register
`timescale 1ns / 1ps
module gh_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output gh_pkg::gh_cmd_t cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign s_ready     = (state_reg == S_IDLE);
    assign out_free    = !m_valid_reg || m_ready;
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == S_EXEC) && out_free;
    assign m_valid     = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd.capture) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait here until the previous word has left the output register
                if (cmd.commit) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/gh_dp.sv
// slot memories, free list head, fill mark, live count and result registers
`timescale 1ns / 1ps
module gh_dp #(
    parameter int SLOTS      = gh_pkg::SLOTS_DEFAULT,
    parameter int VALUE_BITS = gh_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gh_pkg::gh_cmd_t               cmd,
    input  logic [gh_pkg::OP_W-1:0]       s_op,
    input  logic [gh_pkg::HANDLE_W-1:0]   s_handle,
    input  logic [gh_pkg::VALUE_W-1:0]    s_insert_value,
    output logic [gh_pkg::STATUS_W-1:0]   m_status,
    output logic [gh_pkg::HANDLE_W-1:0]   m_new_handle,
    output logic [gh_pkg::VALUE_W-1:0]    m_read_value,
    output logic [gh_pkg::LIVE_W-1:0]     m_live_count
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int GEN_W  = gh_pkg::GEN_W;
    localparam int LIVE_W = gh_pkg::LIVE_W;

    logic [gh_pkg::OP_W-1:0]     op_reg;
    logic [gh_pkg::HANDLE_W-1:0] handle_reg;
    logic [gh_pkg::VALUE_W-1:0]  value_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [LINK_W-1:0]           head_reg;
    logic [LINK_W-1:0]           head_next;
    logic [LINK_W-1:0]           hwm_reg;
    logic [LINK_W-1:0]           hwm_next;
    logic [LIVE_W-1:0]           live_reg;
    logic [LIVE_W-1:0]           live_next;
    logic [gh_pkg::STATUS_W-1:0] status_reg;
    logic [gh_pkg::STATUS_W-1:0] status_next;
    logic [gh_pkg::HANDLE_W-1:0] new_handle_reg;
    logic [gh_pkg::HANDLE_W-1:0] new_handle_next;
    logic [gh_pkg::VALUE_W-1:0]  read_value_reg;
    logic [gh_pkg::VALUE_W-1:0]  read_value_next;

    logic [IDX_W-1:0]      rd_addr;
    logic [GEN_W-1:0]      gen_rd;
    logic [LINK_W-1:0]     link_rd;
    logic [VALUE_BITS-1:0] pay_rd;

    logic             fresh;
    logic [GEN_W-1:0] gen_cur;
    logic [GEN_W-1:0] gen_inc;
    logic [LINK_W-1:0] link_cur;
    logic [GEN_W-1:0] hgen;
    logic             in_range;
    logic             match;
    logic             head_ok;
    logic             ins_ok;
    logic             rem_ok;
    logic             get_ok;
    logic             retire;
    logic             gen_we;
    logic             link_we;
    logic             pay_we;

    assign rd_addr = (s_op == gh_pkg::OP_INSERT) ? head_reg[IDX_W-1:0]
                                                 : s_handle[IDX_W-1:0];

    gh_ram #(.WIDTH(GEN_W), .DEPTH(SLOTS)) u_gen_ram (
        .aclk    (aclk),
        .wr_en   (gen_we),
        .wr_addr (idx_reg),
        .wr_data (gen_inc),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (gen_rd)
    );

    gh_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (idx_reg),
        .wr_data (head_reg),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (link_rd)
    );

    gh_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (pay_we),
        .wr_addr (idx_reg),
        .wr_data (VALUE_BITS'(value_reg)),
        .rd_en   (cmd.capture),
        .rd_addr (rd_addr),
        .rd_data (pay_rd)
    );

    // slots at or above the fill mark were never inserted: generation zero, link i+1
    assign fresh    = LINK_W'(idx_reg) >= hwm_reg;
    assign gen_cur  = fresh ? '0 : gen_rd;
    assign link_cur = fresh ? (LINK_W'(idx_reg) + LINK_W'(1)) : link_rd;
    // all-ones wraps to zero, which is exactly the retire case
    assign gen_inc  = gen_cur + GEN_W'(1);

    assign hgen     = handle_reg[gh_pkg::HANDLE_W-1:gh_pkg::INDEX_W];
    assign in_range = handle_reg[gh_pkg::INDEX_W-1:0] < gh_pkg::INDEX_W'(SLOTS);
    assign match    = in_range && hgen[0] && (gen_cur == hgen);
    assign head_ok  = head_reg < LINK_W'(SLOTS);
    assign retire   = (gen_cur == '1);

    assign ins_ok = (op_reg == gh_pkg::OP_INSERT) && head_ok && !gen_cur[0];
    assign rem_ok = (op_reg == gh_pkg::OP_REMOVE) && match;
    assign get_ok = (op_reg == gh_pkg::OP_GET) && match;

    assign gen_we  = cmd.commit && (ins_ok || rem_ok);
    assign link_we = cmd.commit && rem_ok && !retire;
    assign pay_we  = cmd.commit && ins_ok;

    always_comb begin
        head_next       = head_reg;
        hwm_next        = hwm_reg;
        live_next       = live_reg;
        new_handle_next = '0;
        read_value_next = '0;
        status_next     = gh_pkg::ST_STALE;
        case (op_reg)
            gh_pkg::OP_INSERT: begin
                status_next = gh_pkg::ST_FULL;
                if (ins_ok) begin
                    status_next     = gh_pkg::ST_OK;
                    head_next       = link_cur;
                    live_next       = live_reg + LIVE_W'(1);
                    new_handle_next = {gen_inc, gh_pkg::INDEX_W'(idx_reg)};
                    if (fresh) begin
                        hwm_next = hwm_reg + LINK_W'(1);
                    end
                end
            end
            gh_pkg::OP_REMOVE: begin
                if (rem_ok) begin
                    status_next = gh_pkg::ST_OK;
                    live_next   = live_reg - LIVE_W'(1);
                    if (!retire) begin
                        head_next = LINK_W'(idx_reg);
                    end
                end
            end
            gh_pkg::OP_GET: begin
                if (get_ok) begin
                    status_next     = gh_pkg::ST_OK;
                    read_value_next = gh_pkg::VALUE_W'(pay_rd);
                end
            end
            default: begin
                status_next = gh_pkg::ST_STALE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            hwm_reg  <= '0;
            live_reg <= '0;
        end else if (cmd.commit) begin
            head_reg <= head_next;
            hwm_reg  <= hwm_next;
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_op;
            handle_reg <= s_handle;
            value_reg  <= s_insert_value;
            idx_reg    <= rd_addr;
        end
        if (cmd.commit) begin
            status_reg     <= status_next;
            new_handle_reg <= new_handle_next;
            read_value_reg <= read_value_next;
        end
    end

    assign m_status     = status_reg;
    assign m_new_handle = new_handle_reg;
    assign m_read_value = read_value_reg;
    assign m_live_count = live_reg;

endmodule

FILE: design/generational_handle_table.sv
// Generational handle table: insert, remove and get on 64-bit handles
// (generation in 63:32, index in 31:0). An operation's word is taken in the
// idle state while the slot's generation, link and payload are read from three
// rams at one address; in the exec state the checks run, the slot is written
// back and the result register is loaded. The exec state waits while an earlier
// result is still held on the m_ side, and a new word is taken while a result
// waits. The table is usable straight after reset with no clearing pass: a fill
// mark tracks how far the free list has reached into never-used slots, which
// read as generation zero. live_count wraps modulo 512.
`timescale 1ns / 1ps
module generational_handle_table #(
    parameter int SLOTS      = gh_pkg::SLOTS_DEFAULT,
    parameter int VALUE_BITS = gh_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gh_pkg::OP_W-1:0]       s_op,
    input  logic [gh_pkg::HANDLE_W-1:0]   s_handle,
    input  logic [gh_pkg::VALUE_W-1:0]    s_insert_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gh_pkg::STATUS_W-1:0]   m_status,
    output logic [gh_pkg::HANDLE_W-1:0]   m_new_handle,
    output logic [gh_pkg::VALUE_W-1:0]    m_read_value,
    output logic [gh_pkg::LIVE_W-1:0]     m_live_count
);

    gh_pkg::gh_cmd_t cmd;

    gh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    gh_dp #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_op           (s_op),
        .s_handle       (s_handle),
        .s_insert_value (s_insert_value),
        .m_status       (m_status),
        .m_new_handle   (m_new_handle),
        .m_read_value   (m_read_value),
        .m_live_count   (m_live_count)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_ready)
        else $error("new word taken before the previous one committed");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("committed result not presented");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != gh_pkg::ST_OK)) |->
            ((m_new_handle == '0) && (m_read_value == '0)))
        else $error("failed operation carries nonzero payload");

endmodule
